@@ rtl/core/atp_pkg.sv @@
// atp_pkg: shared types, register offsets, op and alias codes for the alarm timer.
// No dependencies; imported by the interfaces, atp_core and alarm_timer_peripheral.
package atp_pkg;

    localparam int WORD_W   = 32;
    localparam int OFFSET_W = 12;
    localparam int PULSE_W  = 4;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    localparam logic [1:0] ALIAS_NORMAL = 2'd0;
    localparam logic [1:0] ALIAS_XOR    = 2'd1;
    localparam logic [1:0] ALIAS_SET    = 2'd2;
    localparam logic [1:0] ALIAS_CLEAR  = 2'd3;

    localparam logic [OFFSET_W-1:0] OFF_TIMEHW   = 12'h000;
    localparam logic [OFFSET_W-1:0] OFF_TIMELW   = 12'h004;
    localparam logic [OFFSET_W-1:0] OFF_TIMEHR   = 12'h008;
    localparam logic [OFFSET_W-1:0] OFF_TIMELR   = 12'h00C;
    localparam logic [OFFSET_W-1:0] OFF_ALARM0   = 12'h010;
    localparam logic [OFFSET_W-1:0] OFF_ARMED    = 12'h020;
    localparam logic [OFFSET_W-1:0] OFF_TIMERAWH = 12'h024;
    localparam logic [OFFSET_W-1:0] OFF_TIMERAWL = 12'h028;
    localparam logic [OFFSET_W-1:0] OFF_INTR     = 12'h034;
    localparam logic [OFFSET_W-1:0] OFF_INTE     = 12'h038;
    localparam logic [OFFSET_W-1:0] OFF_INTF     = 12'h03C;

    typedef struct packed {
        logic [1:0]          op;
        logic [OFFSET_W-1:0] reg_offset;
        logic [1:0]          alias_req;
        logic [WORD_W-1:0]   wr_data;
    } req_t;

    typedef struct packed {
        logic [WORD_W-1:0]  rd_data;
        logic [PULSE_W-1:0] irq_pulse;
    } rsp_t;

    function automatic logic [WORD_W-1:0] apply_alias(
        input logic [WORD_W-1:0] cur,
        input logic [WORD_W-1:0] data,
        input logic [1:0]        alias_code
    );
        logic [WORD_W-1:0] res;
        case (alias_code)
            ALIAS_XOR:   res = cur ^ data;
            ALIAS_SET:   res = cur | data;
            ALIAS_CLEAR: res = cur & ~data;
            default:     res = data;
        endcase
        return res;
    endfunction

endpackage

@@ rtl/core/atp_req_if.sv @@
// atp_req_if: request channel (tick, bus read, bus write) with valid/ready.
// Depends on atp_pkg for field widths.
interface atp_req_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    op;
    logic [atp_pkg::OFFSET_W-1:0]  reg_offset;
    logic [1:0]                    alias_req;
    logic [atp_pkg::WORD_W-1:0]    wr_data;

    modport source (output valid, op, reg_offset, alias_req, wr_data, input ready);
    modport sink   (input valid, op, reg_offset, alias_req, wr_data, output ready);
endinterface

@@ rtl/core/atp_rsp_if.sv @@
// atp_rsp_if: result channel (read data and interrupt pulses) with valid/ready.
// Depends on atp_pkg for field widths.
interface atp_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [atp_pkg::WORD_W-1:0]    rd_data;
    logic [atp_pkg::PULSE_W-1:0]   irq_pulse;

    modport source (output valid, rd_data, irq_pulse, input ready);
    modport sink   (input valid, rd_data, irq_pulse, output ready);
endinterface

@@ rtl/core/atp_core.sv @@
// atp_core: timer state (counter, alarms, interrupt bits) and its update for one item.
// Depends on atp_pkg; instantiated by alarm_timer_peripheral.
module atp_core #(
    parameter int ALARM_COUNT = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          fire,
    input  atp_pkg::req_t req,
    output atp_pkg::rsp_t rsp
);
    import atp_pkg::*;

    localparam logic [OFFSET_W-1:0] ALARM_END = OFFSET_W'(OFF_ALARM0 + 4 * ALARM_COUNT);

    logic [63:0]             cnt_reg, cnt_next;
    logic [WORD_W-1:0]       alarm_reg [ALARM_COUNT];
    logic [WORD_W-1:0]       alarm_next [ALARM_COUNT];
    logic [ALARM_COUNT-1:0]  armed_reg, armed_next;
    logic [ALARM_COUNT-1:0]  raw_reg, raw_next;
    logic [ALARM_COUNT-1:0]  en_reg, en_next;
    logic [ALARM_COUNT-1:0]  force_reg, force_next;
    logic [WORD_W-1:0]       latched_reg, latched_next;
    logic [WORD_W-1:0]       pending_reg, pending_next;

    logic                    alarm_hit;
    logic [1:0]              alarm_sel;
    logic [WORD_W-1:0]       alias_tmp;
    logic [ALARM_COUNT-1:0]  pulse;
    logic [WORD_W-1:0]       rd;

    assign alarm_hit = (req.reg_offset >= OFF_ALARM0) && (req.reg_offset < ALARM_END)
                       && (req.reg_offset[1:0] == 2'b00);
    assign alarm_sel = req.reg_offset[3:2];

    always_comb
    begin
        cnt_next     = cnt_reg;
        alarm_next   = alarm_reg;
        armed_next   = armed_reg;
        raw_next     = raw_reg;
        en_next      = en_reg;
        force_next   = force_reg;
        latched_next = latched_reg;
        pending_next = pending_reg;
        alias_tmp    = '0;
        pulse        = '0;
        rd           = '0;

        case (req.op)
            OP_TICK:
            begin
                cnt_next = cnt_reg + 64'd1;
                for (int i = 0; i < ALARM_COUNT; i++)
                begin
                    if (armed_reg[i] && (alarm_reg[i] == cnt_next[31:0]))
                    begin
                        raw_next[i]   = 1'b1;
                        armed_next[i] = 1'b0;
                        pulse[i]      = en_reg[i];
                    end
                end
            end
            OP_READ:
            begin
                if (alarm_hit)
                begin
                    for (int i = 0; i < ALARM_COUNT; i++)
                    begin
                        if (alarm_sel == 2'(i))
                            rd = alarm_reg[i];
                    end
                end
                else
                begin
                    unique case (req.reg_offset)
                        OFF_TIMEHR:   rd = latched_reg;
                        OFF_TIMELR:
                        begin
                            latched_next = cnt_reg[63:32];
                            rd           = cnt_reg[31:0];
                        end
                        OFF_ARMED:    rd = WORD_W'(armed_reg);
                        OFF_TIMERAWH: rd = cnt_reg[63:32];
                        OFF_TIMERAWL: rd = cnt_reg[31:0];
                        OFF_INTE:     rd = WORD_W'(en_reg);
                        default:      rd = '0;
                    endcase
                end
            end
            OP_WRITE:
            begin
                if (alarm_hit)
                begin
                    for (int i = 0; i < ALARM_COUNT; i++)
                    begin
                        if (alarm_sel == 2'(i))
                        begin
                            alarm_next[i] = apply_alias(alarm_reg[i], req.wr_data,
                                                        req.alias_req);
                            armed_next[i] = 1'b1;
                        end
                    end
                end
                else
                begin
                    unique case (req.reg_offset)
                        OFF_TIMEHW:
                        begin
                            alias_tmp = apply_alias(cnt_reg[63:32], req.wr_data,
                                                    req.alias_req);
                            cnt_next  = {alias_tmp, pending_reg};
                        end
                        OFF_TIMELW:
                            pending_next = apply_alias(pending_reg, req.wr_data,
                                                       req.alias_req);
                        OFF_ARMED:
                        begin
                            if (req.alias_req == ALIAS_NORMAL)
                                armed_next = armed_reg & ~req.wr_data[ALARM_COUNT-1:0];
                        end
                        OFF_INTR:
                        begin
                            if (req.alias_req == ALIAS_NORMAL)
                                raw_next = raw_reg & ~req.wr_data[ALARM_COUNT-1:0];
                        end
                        OFF_INTE:
                        begin
                            alias_tmp = apply_alias(WORD_W'(en_reg), req.wr_data,
                                                    req.alias_req);
                            en_next   = alias_tmp[ALARM_COUNT-1:0];
                        end
                        OFF_INTF:
                        begin
                            alias_tmp  = apply_alias(WORD_W'(force_reg), req.wr_data,
                                                     req.alias_req);
                            force_next = alias_tmp[ALARM_COUNT-1:0];
                            pulse      = alias_tmp[ALARM_COUNT-1:0] & en_reg;
                        end
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
    end

    assign rsp.rd_data   = rd;
    assign rsp.irq_pulse = PULSE_W'(pulse);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            for (int i = 0; i < ALARM_COUNT; i++)
                alarm_reg[i] <= '0;
            armed_reg   <= '0;
            raw_reg     <= '0;
            en_reg      <= '0;
            force_reg   <= '0;
            latched_reg <= '0;
            pending_reg <= '0;
        end
        else if (fire)
        begin
            cnt_reg     <= cnt_next;
            alarm_reg   <= alarm_next;
            armed_reg   <= armed_next;
            raw_reg     <= raw_next;
            en_reg      <= en_next;
            force_reg   <= force_next;
            latched_reg <= latched_next;
            pending_reg <= pending_next;
        end
    end

    // reads never move the counter
    a_read_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (req.op == OP_READ) |=> $stable(cnt_reg))
        else $error("counter changed on a read");

    a_idle_keeps_bits: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(armed_reg) && $stable(raw_reg))
        else $error("interrupt state changed without a transfer");

    // raw bits are only raised by an alarm match on a tick
    a_raw_set_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (req.op != OP_TICK) |=> (raw_reg & ~$past(raw_reg)) == '0)
        else $error("raw interrupt bit set outside a tick");

endmodule

@@ rtl/core/alarm_timer_peripheral.sv @@
// alarm_timer_peripheral: 64-bit tick counter with alarms, input and result registers.
// Depends on atp_pkg, atp_req_if, atp_rsp_if and atp_core.
//
//   channel | dir | payload                               | transfer
//   req     | in  | op, reg_offset, alias_req, wr_data    | req.valid && req.ready
//   rsp     | out | rd_data, irq_pulse                    | rsp.valid && rsp.ready
//
// One item per cycle sustained while results are taken; a stalled result holds the flow.
// Each item passes through the input register, then the single-pass state update into
// the result register, from which it is offered until the result transfer.
// Reset clears the valid flags and all core state to zero at once; no clearing pass.
// req.ready stays high unless the input register is full behind a stalled result.
module alarm_timer_peripheral #(
    parameter int ALARM_COUNT = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    atp_req_if.sink       req,
    atp_rsp_if.source     rsp
);
    import atp_pkg::*;

    logic  s1_valid_reg;
    req_t  s1_req_reg;
    logic  rsp_valid_reg;
    rsp_t  rsp_reg;
    rsp_t  rsp_next;
    logic  fire;

    assign fire      = s1_valid_reg && (!rsp_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.ready)
                s1_valid_reg <= req.valid;
            if (fire)
                rsp_valid_reg <= 1'b1;
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            s1_req_reg.op         <= req.op;
            s1_req_reg.reg_offset <= req.reg_offset;
            s1_req_reg.alias_req  <= req.alias_req;
            s1_req_reg.wr_data    <= req.wr_data;
        end
        if (fire)
            rsp_reg <= rsp_next;
    end

    atp_core #(
        .ALARM_COUNT (ALARM_COUNT)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .req   (s1_req_reg),
        .rsp   (rsp_next)
    );

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.rd_data   = rsp_reg.rd_data;
    assign rsp.irq_pulse = rsp_reg.irq_pulse;

    a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> rsp_valid_reg)
        else $error("processed item left no result");

    a_ready_low_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !req.ready |-> s1_valid_reg && rsp_valid_reg && !rsp.ready)
        else $error("request stalled with room available");

    a_held_item_stays: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !fire |=> s1_valid_reg && $stable(s1_req_reg))
        else $error("waiting item lost or altered");

endmodule
